// ===== src/hrs_pkg.sv =====
// hrs_pkg: shared widths, mode and function codes, and state and request types
// for the hvac relay sequencer; no dependencies
package hrs_pkg;

  localparam int TIME_W  = 32;
  localparam int MODE_W  = 3;
  localparam int DELAY_W = 22;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 22'd300000;

  localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FAN      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COOL     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HEAT_PMP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALT_ONE  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ALT_TWO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LAST     = MODE_ALT_TWO;

  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now;
    logic [MODE_W-1:0] requested_mode;
    logic              queue_enabled;
  } req_t;

  typedef struct packed {
    logic [MODE_W-1:0] cur_mode;
    logic [MODE_W-1:0] next_mode;
    logic [TIME_W-1:0] due_time;
    logic              running;
    logic              prefer_flag;
    logic [TIME_W-1:0] change_stamp;
    logic [TIME_W-1:0] idle_stamp;
  } state_t;

endpackage

// ===== src/hrs_step.sv =====
// hrs_step: next-state logic for one request (tick or mode request)
// depends on hrs_pkg
module hrs_step (
  input  hrs_pkg::state_t                 cur_st,
  input  hrs_pkg::req_t                   req,
  input  logic [hrs_pkg::DELAY_W-1:0]     switch_delay,
  output hrs_pkg::state_t                 nxt_st
);

  logic [hrs_pkg::TIME_W-1:0] due_sum;

  assign due_sum = req.now + {{(hrs_pkg::TIME_W-hrs_pkg::DELAY_W){1'b0}}, switch_delay};

  always_comb begin
    nxt_st = cur_st;
    if (req.func == hrs_pkg::FUNC_REQUEST) begin
      if (req.requested_mode == hrs_pkg::MODE_IDLE) begin
        nxt_st.next_mode    = hrs_pkg::MODE_IDLE;
        nxt_st.cur_mode     = hrs_pkg::MODE_IDLE;
        nxt_st.due_time     = '0;
        nxt_st.change_stamp = req.now;
      end else if (req.requested_mode <= hrs_pkg::MODE_LAST &&
                   req.requested_mode != cur_st.cur_mode &&
                   req.requested_mode != cur_st.next_mode) begin
        // drop to idle first when a mode is applied
        if (cur_st.cur_mode != hrs_pkg::MODE_IDLE) begin
          nxt_st.cur_mode     = hrs_pkg::MODE_IDLE;
          nxt_st.due_time     = '0;
          nxt_st.change_stamp = req.now;
        end
        nxt_st.next_mode = req.requested_mode;
        if (nxt_st.due_time == '0 || req.now >= nxt_st.due_time) begin
          nxt_st.due_time = due_sum;
        end
      end
    end else begin
      if (cur_st.cur_mode != hrs_pkg::MODE_IDLE && !cur_st.running) begin
        nxt_st.running     = 1'b1;
        nxt_st.prefer_flag = 1'b0;
      end else if (cur_st.cur_mode == hrs_pkg::MODE_IDLE && cur_st.running) begin
        nxt_st.running     = 1'b0;
        nxt_st.prefer_flag = 1'b1;
        nxt_st.idle_stamp  = req.now;
      end
      if (req.queue_enabled && cur_st.due_time != '0 && req.now > cur_st.due_time &&
          cur_st.next_mode != cur_st.cur_mode) begin
        nxt_st.cur_mode     = cur_st.next_mode;
        nxt_st.due_time     = '0;
        nxt_st.change_stamp = req.now;
      end
    end
  end

endmodule

// ===== src/hrs_out_reg.sv =====
// hrs_out_reg: result register holding the updated state, relay decode
// depends on hrs_pkg
module hrs_out_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  hrs_pkg::state_t             st,
  output logic                        can_load,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        relay_fan,
  output logic                        relay_cool,
  output logic                        relay_heat_pump,
  output logic                        relay_alt_one,
  output logic                        relay_alt_two,
  output logic [hrs_pkg::MODE_W-1:0]  active_mode,
  output logic [hrs_pkg::MODE_W-1:0]  waiting_mode,
  output logic                        prefer_update,
  output logic [hrs_pkg::TIME_W-1:0]  last_change_time,
  output logic [hrs_pkg::TIME_W-1:0]  last_idle_time
);

  logic            valid_r;
  logic            valid_nxt;
  hrs_pkg::state_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= st;
    end
  end

  assign out_valid        = valid_r;
  assign relay_fan        = (res_r.cur_mode == hrs_pkg::MODE_FAN);
  assign relay_cool       = (res_r.cur_mode == hrs_pkg::MODE_COOL);
  assign relay_heat_pump  = (res_r.cur_mode == hrs_pkg::MODE_HEAT_PMP);
  assign relay_alt_one    = (res_r.cur_mode == hrs_pkg::MODE_ALT_ONE);
  assign relay_alt_two    = (res_r.cur_mode == hrs_pkg::MODE_ALT_TWO);
  assign active_mode      = res_r.cur_mode;
  assign waiting_mode     = res_r.next_mode;
  assign prefer_update    = res_r.prefer_flag;
  assign last_change_time = res_r.change_stamp;
  assign last_idle_time   = res_r.idle_stamp;

endmodule

// ===== src/hvac_relay_sequencer_top.sv =====
// hvac_relay_sequencer_top: sequencer state, switch delay register, top ports
// depends on hrs_pkg, hrs_step, hrs_out_reg
//
// One request (tick or mode request) is accepted per clock; its result appears
// in the output register on the next cycle, so the unstalled rate is one request
// per cycle. The state update is a single pass of compare and 32-bit add logic.
// in_ready drops only while a result is held and out_ready is low. The switch
// delay register may be written whenever the block is idle; it resets to 300000.
module hvac_relay_sequencer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hrs_pkg::DELAY_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [hrs_pkg::TIME_W-1:0]  in_now,
  input  logic [hrs_pkg::MODE_W-1:0]  in_requested_mode,
  input  logic                        in_queue_enabled,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_relay_fan,
  output logic                        out_relay_cool,
  output logic                        out_relay_heat_pump,
  output logic                        out_relay_alt_one,
  output logic                        out_relay_alt_two,
  output logic [hrs_pkg::MODE_W-1:0]  out_active_mode,
  output logic [hrs_pkg::MODE_W-1:0]  out_waiting_mode,
  output logic                        out_prefer_update,
  output logic [hrs_pkg::TIME_W-1:0]  out_last_change_time,
  output logic [hrs_pkg::TIME_W-1:0]  out_last_idle_time
);

  logic [hrs_pkg::DELAY_W-1:0] delay_r;
  hrs_pkg::state_t             state_r;
  hrs_pkg::state_t             state_nxt;
  hrs_pkg::req_t               req;
  logic                        accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign req.func           = in_func;
  assign req.now            = in_now;
  assign req.requested_mode = in_requested_mode;
  assign req.queue_enabled  = in_queue_enabled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= hrs_pkg::DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delay_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  hrs_step u_step (
    .cur_st       (state_r),
    .req          (req),
    .switch_delay (delay_r),
    .nxt_st       (state_nxt)
  );

  hrs_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (accept),
    .st               (state_nxt),
    .can_load         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .relay_fan        (out_relay_fan),
    .relay_cool       (out_relay_cool),
    .relay_heat_pump  (out_relay_heat_pump),
    .relay_alt_one    (out_relay_alt_one),
    .relay_alt_two    (out_relay_alt_two),
    .active_mode      (out_active_mode),
    .waiting_mode     (out_waiting_mode),
    .prefer_update    (out_prefer_update),
    .last_change_time (out_last_change_time),
    .last_idle_time   (out_last_idle_time)
  );

  a_idle_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == hrs_pkg::FUNC_REQUEST && in_requested_mode == hrs_pkg::MODE_IDLE
    |=> state_r.cur_mode == hrs_pkg::MODE_IDLE && state_r.due_time == '0)
    else $error("idle request did not clear mode");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while result stalled");

  a_relay_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_relay_fan, out_relay_cool, out_relay_heat_pump,
                            out_relay_alt_one, out_relay_alt_two}))
    else $error("more than one relay driven");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.cur_mode <= hrs_pkg::MODE_LAST && state_r.next_mode <= hrs_pkg::MODE_LAST)
    else $error("mode register out of range");

endmodule
